>>> hdl/merge_sort_engine_top_assert.svh
`ifndef MERGE_SORT_ENGINE_TOP_ASSERT_SVH
`define MERGE_SORT_ENGINE_TOP_ASSERT_SVH
// concurrent assertion helpers
`define MSE_ASSERT_IMPL(lbl, clk_i, rst_n_i, prop_i) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) prop_i) \
		else $error("assertion failed");
`define MSE_ASSERT_NEVER(lbl, clk_i, rst_n_i, cond_i) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) !(cond_i)) \
		else $error("forbidden condition");
`endif

>>> hdl/mse_pkg.sv
package mse_pkg;
	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_PASS_INIT,
		ST_MERGE,
		ST_COPY,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [15:0] key;
		logic        last;
	} item_t;
endpackage

>>> hdl/mse_front.sv
module mse_front #(
	parameter int KEY_WIDTH = 16
) (
	input  logic                 start,
	input  logic [15:0]          key,
	input  logic                 last,
	input  logic                 q_full,
	output logic                 busy,
	output logic                 q_push,
	output mse_pkg::item_t       q_item
);
	logic [15:0] mask;
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			mask[i] = (i < KEY_WIDTH);
		end
	end

	assign busy = q_full;
	assign q_push = start && !q_full;
	assign q_item.key = key & mask;
	assign q_item.last = last;
endmodule

>>> hdl/mse_fifo.sv
module mse_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mse_pkg::item_t din,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output mse_pkg::item_t dout
);
	mse_pkg::item_t mem_q [2];
	logic [1:0] wp_q;
	logic [1:0] rp_q;

	assign empty = (wp_q == rp_q);
	assign full = (wp_q[1] != rp_q[1]) && (wp_q[0] == rp_q[0]);
	assign dout = mem_q[rp_q[0]];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q[0]] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 2'd1;
			end
			if (pop) begin
				rp_q <= rp_q + 2'd1;
			end
		end
	end
endmodule

>>> hdl/mse_back.sv
module mse_back #(
	parameter int MAX_KEYS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  mse_pkg::item_t q_item,
	output logic           q_pop,
	output logic           res_valid,
	output logic [15:0]    sorted_key,
	output logic           final_res,
	output logic           overflow
);
	localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CW = $clog2(MAX_KEYS + 1) + 1;

	mse_pkg::state_t state_q, state_d;

	logic [15:0] store_q [MAX_KEYS];
	logic [15:0] buf_q [MAX_KEYS];

	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic [CW-1:0] run_q;
	logic [CW-1:0] lo_q, a_q, b_q, mid_q, hi_q, w_q;
	logic [CW-1:0] n_mid, n_hi;
	logic [15:0]   ra_q, rb_q;
	logic          rd_ok_q;
	logic [15:0]   cp_q;
	logic [CW-1:0] cp_w_q;
	logic          cp_ok_q;

	logic          take_b;
	logic          a_more, b_more;
	logic          adv;
	logic [CW-1:0] a_nx, b_nx;
	logic [CW-1:0] rd_a, rd_b;

	assign a_more = (a_q < mid_q);
	assign b_more = (b_q < hi_q);
	assign take_b = b_more && (!a_more || (rb_q < ra_q));
	assign a_nx = a_q + CW'(1);
	assign b_nx = b_q + CW'(1);
	assign n_mid = lo_q + run_q;
	assign n_hi = ((n_mid + run_q) > cnt_q) ? cnt_q : (n_mid + run_q);
	assign adv = (state_q == mse_pkg::ST_MERGE) && rd_ok_q && (a_more || b_more);
	// read ahead so the compare always sees the current heads
	assign rd_a = (state_q == mse_pkg::ST_EMIT) ? w_q : ((adv && !take_b) ? a_nx : a_q);
	assign rd_b = (adv && take_b) ? b_nx : b_q;
	assign sorted_key = ra_q;

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		unique case (state_q)
			mse_pkg::ST_COLLECT: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (q_item.last) begin
						state_d = mse_pkg::ST_PASS_INIT;
					end
				end
			end
			mse_pkg::ST_PASS_INIT: begin
				if (run_q >= cnt_q) begin
					state_d = mse_pkg::ST_EMIT;
				end else if (n_mid < cnt_q) begin
					state_d = mse_pkg::ST_MERGE;
				end
			end
			mse_pkg::ST_MERGE: begin
				if (rd_ok_q && !a_more && !b_more) begin
					state_d = mse_pkg::ST_COPY;
				end
			end
			mse_pkg::ST_COPY: begin
				if (w_q + CW'(1) >= hi_q) begin
					state_d = mse_pkg::ST_PASS_INIT;
				end
			end
			mse_pkg::ST_EMIT: begin
				if (w_q + CW'(1) >= cnt_q) begin
					state_d = mse_pkg::ST_COLLECT;
				end
			end
			default: state_d = mse_pkg::ST_COLLECT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mse_pkg::ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mse_pkg::ST_COLLECT && !q_empty && cnt_q < CW'(MAX_KEYS)) begin
			store_q[cnt_q[AW-1:0]] <= q_item.key;
		end
		// copy back writes the registered buffer read in the following cycle
		if (cp_ok_q) begin
			store_q[cp_w_q[AW-1:0]] <= cp_q;
		end
		if (adv) begin
			buf_q[w_q[AW-1:0]] <= take_b ? rb_q : ra_q;
		end
		cp_q <= buf_q[w_q[AW-1:0]];
		cp_w_q <= w_q;
		ra_q <= store_q[rd_a[AW-1:0]];
		rb_q <= store_q[rd_b[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			run_q <= '0;
			lo_q <= '0;
			a_q <= '0;
			b_q <= '0;
			mid_q <= '0;
			hi_q <= '0;
			w_q <= '0;
			rd_ok_q <= 1'b0;
			cp_ok_q <= 1'b0;
			res_valid <= 1'b0;
			final_res <= 1'b0;
			overflow <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			final_res <= 1'b0;
			overflow <= 1'b0;
			rd_ok_q <= 1'b0;
			cp_ok_q <= (state_q == mse_pkg::ST_COPY);
			unique case (state_q)
				mse_pkg::ST_COLLECT: begin
					if (!q_empty) begin
						if (cnt_q < CW'(MAX_KEYS)) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					run_q <= CW'(1);
					lo_q <= '0;
					w_q <= '0;
				end
				mse_pkg::ST_PASS_INIT: begin
					if (run_q >= cnt_q) begin
						w_q <= '0;
					end else if (n_mid < cnt_q) begin
						a_q <= lo_q;
						b_q <= n_mid;
						mid_q <= n_mid;
						hi_q <= n_hi;
						w_q <= lo_q;
					end else begin
						run_q <= run_q << 1;
						lo_q <= '0;
					end
				end
				mse_pkg::ST_MERGE: begin
					if (!rd_ok_q) begin
						rd_ok_q <= 1'b1;
					end else if (a_more || b_more) begin
						rd_ok_q <= 1'b1;
						w_q <= w_q + CW'(1);
						if (take_b) begin
							b_q <= b_nx;
						end else begin
							a_q <= a_nx;
						end
					end else begin
						w_q <= lo_q;
					end
				end
				mse_pkg::ST_COPY: begin
					if (w_q + CW'(1) >= hi_q) begin
						if (hi_q >= cnt_q) begin
							run_q <= run_q << 1;
							lo_q <= '0;
						end else begin
							lo_q <= hi_q;
						end
					end else begin
						w_q <= w_q + CW'(1);
					end
				end
				mse_pkg::ST_EMIT: begin
					res_valid <= 1'b1;
					overflow <= ovf_q;
					w_q <= w_q + CW'(1);
					if (w_q + CW'(1) >= cnt_q) begin
						final_res <= 1'b1;
						cnt_q <= '0;
						ovf_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

>>> hdl/merge_sort_engine_top.sv
// batch sorter: keys enter one per transaction while busy is low; the transaction
// with last set closes the batch, then n keys (at most MAX_KEYS) come out in
// ascending order, one per cycle on done, each present for exactly one cycle
// since the receiver cannot stall. while collecting, one key is taken per cycle;
// during sort and output a two-entry queue takes two more keys, then busy stays
// high until the batch has been sent. sorting is a bottom-up merge: each pass
// merges pairs of runs from the key memory into a buffer memory and copies them
// back, and the run length doubles per pass; extra keys set overflow
module merge_sort_engine_top #(
	parameter int MAX_KEYS = 64,
	parameter int KEY_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] key,
	input  logic        last,
	output logic        busy,
	output logic        done,
	output logic [15:0] sorted_key,
	output logic        final_res,
	output logic        overflow
);
	logic           q_push, q_pop, q_full, q_empty;
	mse_pkg::item_t f_item, b_item;

	mse_front #(.KEY_WIDTH(KEY_WIDTH)) u_front (
		.start(start), .key(key), .last(last),
		.q_full(q_full), .busy(busy), .q_push(q_push), .q_item(f_item)
	);

	mse_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(q_push), .din(f_item), .pop(q_pop),
		.full(q_full), .empty(q_empty), .dout(b_item)
	);

	mse_back #(.MAX_KEYS(MAX_KEYS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_item(b_item),
		.q_pop(q_pop), .res_valid(done), .sorted_key(sorted_key),
		.final_res(final_res), .overflow(overflow)
	);
endmodule

>>> hdl/mse_checker.sv
`include "merge_sort_engine_top_assert.svh"
module mse_checker (
	input logic clk,
	input logic arst_n,
	input logic done,
	input logic final_res,
	input logic overflow
);
	`MSE_ASSERT_NEVER(a_final_needs_done, clk, arst_n, final_res && !done)
	`MSE_ASSERT_NEVER(a_ovf_needs_done, clk, arst_n, overflow && !done)
	`MSE_ASSERT_IMPL(a_ovf_hold, clk, arst_n, done && $past(done && !final_res) |-> overflow == $past(overflow))
endmodule

bind merge_sort_engine_top mse_checker u_chk (
	.clk(clk), .arst_n(arst_n), .done(done),
	.final_res(final_res), .overflow(overflow)
);
